>>> rtl/frefl_pkg.sv
// Package for the Fresnel reflectance pipeline.
// Holds shared constants and the side-band struct; no dependencies.
package frefl_pkg;

    localparam int FRACTION_BITS_DEF = 14;
    localparam logic [15:0] KR_ONE = 16'd32768;

    // Values that ride along with an item through the long arithmetic stages
    typedef struct packed {
        logic [30:0] c;
        logic [15:0] ei;
        logic [15:0] et;
        logic        force_one;
    } t_side;

endpackage

>>> rtl/fresnel_reflectance.sv
// Fresnel reflectance (unpolarized) as a fully pipelined datapath.
// Depends on frefl_pkg.
//
// One request enters per clock, except while the stall below holds the pipeline, and passes
// through 89 register stages: the bit-per-stage divider for sin_t^2 (30 stages), the
// bit-pair-per-stage square root for cos_t (31 stages) and the two parallel ratio dividers
// (17 stages), plus eleven stages of products, sums, final scaling and the output register.
// A single stall enable freezes every stage when the output register holds a result that is
// not taken, so nothing is dropped or repeated.
module fresnel_reflectance #(
    parameter int FRACTION_BITS = frefl_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_ray_x,
    input  logic signed [15:0] i_ray_y,
    input  logic signed [15:0] i_ray_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic        [15:0] i_near_side_index,
    input  logic        [15:0] i_far_side_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [15:0] o_reflect_fraction,
    output logic               o_total_reflection
);
    import frefl_pkg::*;

    localparam int DOT_FB = 2 * FRACTION_BITS;
    localparam int ND1    = 30;
    localparam int NSQ    = 31;
    localparam int ND2    = 17;

    logic w_en;

    // advance all stages unless the output holds a result not yet taken
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // stage 1: component products
    logic               r1_v;
    logic signed [31:0] r1_px, r1_py, r1_pz;
    logic        [15:0] r1_ei, r1_et;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_px <= i_ray_x * i_normal_x;
            r1_py <= i_ray_y * i_normal_y;
            r1_pz <= i_ray_z * i_normal_z;
            r1_ei <= i_near_side_index;
            r1_et <= i_far_side_index;
        end
    end

    // stage 2: dot product, clamp, convert to Q30, swap indices
    logic signed [33:0] w_dot;
    logic        [33:0] w_mag;
    logic        [63:0] w_mag64, w_one, w_cl, w_c64;
    logic               w_swap;
    logic               r2_v;
    t_side              r2_side;

    assign w_dot   = 34'(r1_px) + 34'(r1_py) + 34'(r1_pz);
    assign w_mag   = w_dot[33] ? 34'(-w_dot) : 34'(w_dot);
    assign w_mag64 = {30'b0, w_mag};
    assign w_one   = 64'd1 << DOT_FB;
    assign w_cl    = (w_mag64 > w_one) ? w_one : w_mag64;
    assign w_swap  = !w_dot[33] && (w_dot != 34'sd0);

    generate
        if (DOT_FB >= 30) begin : g_shr
            assign w_c64 = w_cl >> (DOT_FB - 30);
        end else begin : g_shl
            assign w_c64 = w_cl << (30 - DOT_FB);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_side.c         <= w_c64[30:0];
            r2_side.ei        <= w_swap ? r1_et : r1_ei;
            r2_side.et        <= w_swap ? r1_ei : r1_et;
            r2_side.force_one <= (r1_ei == 16'd0) || (r1_et == 16'd0);
        end
    end

    // stage 3: squares
    logic        r3_v;
    logic [61:0] r3_cc;
    logic [31:0] r3_ei2, r3_et2;
    t_side       r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_cc   <= r2_side.c * r2_side.c;
            r3_ei2  <= r2_side.ei * r2_side.ei;
            r3_et2  <= r2_side.et * r2_side.et;
            r3_side <= r2_side;
        end
    end

    // stage 4: sin_i^2 in Q30
    logic        r4_v;
    logic [30:0] r4_s2;
    logic [31:0] r4_ei2, r4_et2;
    logic [31:0] w_s2;
    t_side       r4_side;

    assign w_s2 = 32'd1073741824 - r3_cc[61:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_s2   <= w_s2[30:0];
            r4_ei2  <= r3_ei2;
            r4_et2  <= r3_et2;
            r4_side <= r3_side;
        end
    end

    // stage 5: etai^2 * sin_i^2
    logic        r5_v;
    logic [62:0] r5_num;
    logic [31:0] r5_et2;
    t_side       r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_num  <= r4_ei2 * r4_s2;
            r5_et2  <= r4_et2;
            r5_side <= r4_side;
        end
    end

    // stage 6: total reflection test, load the sin_t^2 divider
    logic        r_d1_v    [0:ND1];
    logic [62:0] r_d1_rem  [0:ND1];
    logic [29:0] r_d1_q    [0:ND1];
    logic [31:0] r_d1_den  [0:ND1];
    t_side       r_d1_side [0:ND1];
    logic        w_tir;
    t_side       w_d1_side;

    assign w_tir = r5_num >= {1'b0, r5_et2, 30'b0};

    // fold total reflection into the forced flag
    always_comb begin
        w_d1_side           = r5_side;
        w_d1_side.force_one = r5_side.force_one || w_tir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v[0] <= 1'b0;
        end else if (w_en) begin
            r_d1_v[0] <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_rem[0]  <= r5_num;
            r_d1_q[0]    <= '0;
            r_d1_den[0]  <= r5_et2;
            r_d1_side[0] <= w_d1_side;
        end
    end

    // sin_t^2 divider: one quotient bit per stage, msb first
    genvar g;
    generate
        for (g = 0; g < ND1; g++) begin : g_div1
            logic [63:0] w_try;
            logic        w_ge;

            assign w_try = {32'b0, r_d1_den[g]} << (ND1 - 1 - g);
            assign w_ge  = {1'b0, r_d1_rem[g]} >= w_try;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_d1_v[g+1] <= 1'b0;
                end else if (w_en) begin
                    r_d1_v[g+1] <= r_d1_v[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_d1_rem[g+1]  <= w_ge ? (r_d1_rem[g] - w_try[62:0]) : r_d1_rem[g];
                    r_d1_q[g+1]    <= {r_d1_q[g][ND1-2:0], w_ge};
                    r_d1_den[g+1]  <= r_d1_den[g];
                    r_d1_side[g+1] <= r_d1_side[g];
                end
            end
        end
    endgenerate

    // load the square root with (1 - sin_t^2) << 30
    logic        r_sq_v    [0:NSQ];
    logic [61:0] r_sq_rem  [0:NSQ];
    logic [61:0] r_sq_res  [0:NSQ];
    t_side       r_sq_side [0:NSQ];
    logic [30:0] w_ct2;

    assign w_ct2 = 31'd1073741824 - {1'b0, r_d1_q[ND1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= r_d1_v[ND1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_rem[0]  <= {1'b0, w_ct2, 30'b0};
            r_sq_res[0]  <= '0;
            r_sq_side[0] <= r_d1_side[ND1];
        end
    end

    // integer square root: one result bit per stage
    generate
        for (g = 0; g < NSQ; g++) begin : g_sqrt
            logic [61:0] w_bit, w_sum;
            logic        w_ge;

            assign w_bit = 62'd1 << (2 * (NSQ - 1 - g));
            assign w_sum = r_sq_res[g] + w_bit;
            assign w_ge  = r_sq_rem[g] >= w_sum;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_v[g+1] <= 1'b0;
                end else if (w_en) begin
                    r_sq_v[g+1] <= r_sq_v[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sq_rem[g+1]  <= w_ge ? (r_sq_rem[g] - w_sum) : r_sq_rem[g];
                    r_sq_res[g+1]  <= w_ge ? ((r_sq_res[g] >> 1) + w_bit)
                                           : (r_sq_res[g] >> 1);
                    r_sq_side[g+1] <= r_sq_side[g];
                end
            end
        end
    endgenerate

    // stage M: the four index-by-cosine products
    logic        rm_v;
    logic [46:0] rm_a, rm_b, rm_c, rm_d;
    logic        rm_f;
    logic [30:0] w_cost;
    t_side       w_sqs;

    assign w_cost = r_sq_res[NSQ][30:0];
    assign w_sqs  = r_sq_side[NSQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_v <= 1'b0;
        end else if (w_en) begin
            rm_v <= r_sq_v[NSQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rm_a <= w_sqs.et * w_sqs.c;
            rm_b <= w_sqs.ei * w_cost;
            rm_c <= w_sqs.ei * w_sqs.c;
            rm_d <= w_sqs.et * w_cost;
            rm_f <= w_sqs.force_one;
        end
    end

    // stage N: differences and sums, load the two ratio dividers
    logic        r_d2_v   [0:ND2];
    logic        r_d2_f   [0:ND2];
    logic [62:0] r_d2_rem [0:1][0:ND2];
    logic [47:0] r_d2_den [0:1][0:ND2];
    logic [16:0] r_d2_q   [0:1][0:ND2];
    logic [47:0] w_den_s, w_den_p;
    logic [46:0] w_num_s, w_num_p;

    assign w_den_s = {1'b0, rm_a} + {1'b0, rm_b};
    assign w_den_p = {1'b0, rm_c} + {1'b0, rm_d};
    assign w_num_s = (rm_a >= rm_b) ? (rm_a - rm_b) : (rm_b - rm_a);
    assign w_num_p = (rm_c >= rm_d) ? (rm_c - rm_d) : (rm_d - rm_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_v[0] <= 1'b0;
        end else if (w_en) begin
            r_d2_v[0] <= rm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_rem[0][0] <= {w_num_s, 16'b0};
            r_d2_rem[1][0] <= {w_num_p, 16'b0};
            r_d2_den[0][0] <= w_den_s;
            r_d2_den[1][0] <= w_den_p;
            r_d2_q[0][0]   <= '0;
            r_d2_q[1][0]   <= '0;
            r_d2_f[0]      <= rm_f || (w_den_s == 48'd0) || (w_den_p == 48'd0);
        end
    end

    // ratio dividers: two lanes, one quotient bit per stage
    generate
        for (g = 0; g < ND2; g++) begin : g_div2
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_d2_v[g+1] <= 1'b0;
                end else if (w_en) begin
                    r_d2_v[g+1] <= r_d2_v[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_d2_f[g+1] <= r_d2_f[g];
                end
            end

            for (genvar l = 0; l < 2; l++) begin : g_lane
                logic [63:0] w_try;
                logic        w_ge;

                assign w_try = {16'b0, r_d2_den[l][g]} << (ND2 - 1 - g);
                assign w_ge  = {1'b0, r_d2_rem[l][g]} >= w_try;

                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_d2_rem[l][g+1] <= w_ge ? (r_d2_rem[l][g] - w_try[62:0])
                                                 : r_d2_rem[l][g];
                        r_d2_den[l][g+1] <= r_d2_den[l][g];
                        r_d2_q[l][g+1]   <= {r_d2_q[l][g][ND2-2:0], w_ge};
                    end
                end
            end
        end
    endgenerate

    // square the two ratios
    logic        rq_v, rq_f;
    logic [33:0] rq_rs2, rq_rp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rq_v <= 1'b0;
        end else if (w_en) begin
            rq_v <= r_d2_v[ND2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rq_rs2 <= r_d2_q[0][ND2] * r_d2_q[0][ND2];
            rq_rp2 <= r_d2_q[1][ND2] * r_d2_q[1][ND2];
            rq_f   <= r_d2_f[ND2];
        end
    end

    // output register: mean, scale to Q1.15, clamp, forced cases
    logic [34:0] w_ksum;
    logic [16:0] w_kr;

    assign w_ksum = {1'b0, rq_rs2} + {1'b0, rq_rp2};
    assign w_kr   = w_ksum[34:18];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= rq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (rq_f) begin
                o_reflect_fraction <= KR_ONE;
                o_total_reflection <= 1'b1;
            end else begin
                o_reflect_fraction <= (w_kr > {1'b0, KR_ONE}) ? KR_ONE : w_kr[15:0];
                o_total_reflection <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/frefl_chk.sv
// Port-level checker for fresnel_reflectance, attached by bind.
// Depends on frefl_pkg.
module frefl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_reflect_fraction,
    input logic        o_total_reflection
);
    import frefl_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_reflect_fraction)
                                && $stable(o_total_reflection))
        else $error("stalled result changed");

    // forced results read as full reflection
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_total_reflection |-> o_reflect_fraction == KR_ONE)
        else $error("total reflection without kr of one");

    // kr never exceeds one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_reflect_fraction <= KR_ONE)
        else $error("kr above one");

    // take requests whenever the output is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid || i_ready |-> o_ready)
        else $error("pipeline stalled with a free output");

endmodule

bind fresnel_reflectance frefl_chk u_frefl_chk (.*);

>>> bench/fresnel_checker.sv
// Checker for the Fresnel reflectance block: predicts kr for every accepted request
// and compares it with the accepted results. Depends on frefl_pkg for constants.
`timescale 1ns / 100ps

module fresnel_checker #(
    parameter int FRACTION_BITS = frefl_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic signed [15:0] i_ray_x,
    input  logic signed [15:0] i_ray_y,
    input  logic signed [15:0] i_ray_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic        [15:0] i_near_side_index,
    input  logic        [15:0] i_far_side_index,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic        [15:0] i_reflect_fraction,
    input  logic               i_total_reflection,
    output int                 o_fail_count,
    output int                 o_pending
);
    import frefl_pkg::*;

    typedef struct packed {
        logic [15:0] kr;
        logic        total;
    } t_kr;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    t_kr kr_queue[$];

    assign o_pending = kr_queue.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (v >= root + bitpos) begin
                v = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // Amplitude ratio |p-q|/(p+q) in Q16; flags a zero denominator
    function automatic logic [63:0] amp_ratio(input logic [63:0] p, input logic [63:0] q,
                                              inout logic degenerate);
        logic [63:0] den;
        logic [63:0] num;
        den = p + q;
        num = (p >= q) ? p - q : q - p;
        if (den == 0) begin
            degenerate = 1'b1;
            return 0;
        end
        return (num << 16) / den;
    endfunction

    function automatic t_kr predict_kr(
        input logic signed [15:0] rx, input logic signed [15:0] ry,
        input logic signed [15:0] rz, input logic signed [15:0] nx,
        input logic signed [15:0] ny, input logic signed [15:0] nz,
        input logic [15:0] near_idx, input logic [15:0] far_idx);
        t_kr res;
        logic signed [63:0] dot;
        logic [63:0] ei, et, tmp, mag, cosi, sin2, sint2, cost, rs, rp, kr;
        logic degenerate;
        res.kr = KR_ONE;
        res.total = 1'b1;
        degenerate = 1'b0;
        dot = 64'(rx) * 64'(nx) + 64'(ry) * 64'(ny) + 64'(rz) * 64'(nz);
        ei = 64'(near_idx);
        et = 64'(far_idx);
        if (ei == 0 || et == 0) return res;
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        if (mag > (64'd1 << (2 * FRACTION_BITS))) mag = 64'd1 << (2 * FRACTION_BITS);
        if (2 * FRACTION_BITS >= 30) cosi = mag >> (2 * FRACTION_BITS - 30);
        else cosi = mag << (30 - 2 * FRACTION_BITS);
        // Ray leaving the material: swap the indices
        if (dot > 0) begin
            tmp = ei;
            ei = et;
            et = tmp;
        end
        sin2 = ONE_Q30 - ((cosi * cosi) >> 30);
        if (ei * ei * sin2 >= et * et * ONE_Q30) return res;
        sint2 = (ei * ei * sin2) / (et * et);
        cost = int_sqrt((ONE_Q30 - sint2) << 30);
        rs = amp_ratio(et * cosi, ei * cost, degenerate);
        rp = amp_ratio(ei * cosi, et * cost, degenerate);
        if (degenerate) return res;
        kr = (rs * rs + rp * rp) >> 18;
        if (kr > 64'(KR_ONE)) kr = 64'(KR_ONE);
        res.kr = kr[15:0];
        res.total = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    // Push predictions for accepted requests, compare accepted results
    always @(posedge i_clk) begin
        t_kr want;
        if (i_rst_n) begin
            if (i_valid && i_ready_in)
                kr_queue.push_back(predict_kr(i_ray_x, i_ray_y, i_ray_z, i_normal_x,
                    i_normal_y, i_normal_z, i_near_side_index, i_far_side_index));
            if (i_out_valid && i_out_ready) begin
                if (kr_queue.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = kr_queue.pop_front();
                    if (i_reflect_fraction !== want.kr)
                        report_mismatch($sformatf("reflect_fraction %0d, expected %0d",
                            i_reflect_fraction, want.kr));
                    if (i_total_reflection !== want.total)
                        report_mismatch($sformatf("total_reflection %0b, expected %0b",
                            i_total_reflection, want.total));
                end
            end
        end
    end

endmodule

>>> bench/tb_fresnel_reflectance.sv
// Top of the Fresnel reflectance bench: clock, reset, request stimulus, result stalls
// and the verdict. Depends on frefl_pkg, fresnel_reflectance and fresnel_checker.
`timescale 1ns / 100ps

module tb_fresnel_reflectance;
    import frefl_pkg::*;

    localparam int LATENCY = 89;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 280;
    localparam logic signed [15:0] UNIT = 16'sd16384;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_ray_x = '0, i_ray_y = '0, i_ray_z = '0;
    logic signed [15:0] i_normal_x = '0, i_normal_y = '0, i_normal_z = '0;
    logic        [15:0] i_near_side_index = '0, i_far_side_index = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic        [15:0] o_reflect_fraction;
    logic               o_total_reflection;

    int         fail_count;
    int         pending;
    int         quiet_cycles = 0;
    t_idle_mode idle_mode = IDLE_NONE;
    bit         hold_off = 1'b0;

    fresnel_reflectance dut (.*);

    fresnel_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready),
        .i_ray_x, .i_ray_y, .i_ray_z, .i_normal_x, .i_normal_y, .i_normal_z,
        .i_near_side_index, .i_far_side_index,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_reflect_fraction(o_reflect_fraction), .i_total_reflection(o_total_reflection),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Drive the result-side ready from the idle mode and the long hold-off
    always @(posedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else if (idle_mode == IDLE_RECV) i_ready <= ($urandom_range(99) >= 66);
        else if (idle_mode == IDLE_BOTH) i_ready <= ($urandom_range(99) >= 29);
        else i_ready <= 1'b1;
    end

    // Watchdog: end the run when nothing is accepted for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || hold_off || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, idling first as the mode asks, and wait for acceptance
    task automatic send_request(input logic [15:0] rx, input logic [15:0] ry,
                                input logic [15:0] rz, input logic [15:0] nx,
                                input logic [15:0] ny, input logic [15:0] nz,
                                input logic [15:0] near_idx, input logic [15:0] far_idx);
        int pct;
        pct = (idle_mode == IDLE_SEND) ? 66 : (idle_mode == IDLE_BOTH) ? 29 : 0;
        while ($urandom_range(99) < pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ray_x <= rx;
        i_ray_y <= ry;
        i_ray_z <= rz;
        i_normal_x <= nx;
        i_normal_y <= ny;
        i_normal_z <= nz;
        i_near_side_index <= near_idx;
        i_far_side_index <= far_idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_index();
        case ($urandom_range(9))
            0: return 16'(0);
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(16'h5000, 16'h2000));
        endcase
    endfunction

    // Direction component between -UNIT and UNIT, or raw noise now and then
    function automatic logic [15:0] rand_comp();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    task automatic send_random();
        logic signed [15:0] ax, ay, az;
        int k;
        k = $urandom_range(3);
        ax = rand_comp();
        ay = rand_comp();
        az = rand_comp();
        // Axis-aligned unit normals half the time, arbitrary ones otherwise
        case (k)
            0: send_request(ax, ay, az, 16'sd0, 16'sd0, UNIT, rand_index(), rand_index());
            1: send_request(ax, ay, az, 16'sd0, -UNIT, 16'sd0, rand_index(), rand_index());
            2: send_request(ax, ay, az, rand_comp(), rand_comp(), rand_comp(),
                            rand_index(), rand_index());
            default: send_request(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom));
        endcase
    endtask

    initial begin
        t_idle_mode modes[4];
        modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: head-on entry and exit, grazing, extremes, zero indices
        send_request(0, 0, -UNIT, 0, 0, UNIT, 16'd8192, 16'd12288);
        send_request(0, 0, UNIT, 0, 0, UNIT, 16'd12288, 16'd8192);
        send_request(UNIT, 0, 0, 0, 0, UNIT, 16'd8192, 16'd12288);
        send_request(16'sd11585, 0, 16'sd11585, 0, 0, UNIT, 16'd12288, 16'd8192);
        send_request(0, 0, -UNIT, 0, 0, UNIT, 16'd0, 16'd8192);
        send_request(0, 0, -UNIT, 0, 0, UNIT, 16'd8192, 16'd0);
        send_request(0, 0, -UNIT, 0, 0, UNIT, 16'd0, 16'd0);
        send_request(0, 0, -UNIT, 0, 0, UNIT, 16'd8192, 16'd8192);
        send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                     16'hFFFF, 16'h0001);
        send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                     16'h0001, 16'hFFFF);
        send_request(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                     16'hFFFF, 16'hFFFF);
        send_request(16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'hAAAA, 16'h5555,
                     16'h5555, 16'hAAAA);
        send_request(16'sd100, 16'sd0, -16'sd16000, 0, 0, UNIT, 16'd1, 16'd1);
        send_request(0, 0, 0, 0, 0, 0, 16'd8192, 16'd12288);
        drain_results();

        // Long receiver hold-off while requests keep coming, so the pipe backs up
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (150) send_random();
        join
        drain_results();

        foreach (modes[m]) begin
            idle_mode = modes[m];
            repeat (RANDOM_ITEMS / 4) send_random();
            // stretch of no idling within the phase
            idle_mode = IDLE_NONE;
            repeat (20) send_random();
            drain_results();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

>>> fresnel_reflectance.f
rtl/frefl_pkg.sv
rtl/fresnel_reflectance.sv
rtl/frefl_chk.sv
bench/fresnel_checker.sv
bench/tb_fresnel_reflectance.sv
